[rtl/fmpt_pkg.sv]
`default_nettype none

package fmpt_pkg;

    // Field widths
    localparam int OP_W       = 2;
    localparam int LOAD_W     = 32;
    localparam int CNT_W      = 16;
    localparam int PPL_W      = 16;
    localparam int MS_W       = 16;
    localparam int WIN_W      = 26;
    localparam int FLOW_W     = 32;
    localparam int TOTAL_W    = 32;
    localparam int TOTAL_ML_W = 42;
    localparam int PROD_W     = 42;
    localparam int FLOW_DEN_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Item opcodes
    localparam logic [OP_W-1:0] OP_PULSE  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;
    localparam logic [OP_W-1:0] OP_STATUS = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_LITRE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MS        = 1'd1;

    localparam logic [PPL_W-1:0] PPL_RESET = 16'd450;
    localparam logic [MS_W-1:0]  MS_RESET  = 16'd1000;

    // mL per litre times ms per minute
    localparam logic [PROD_W-1:0] ML_MIN_PER_LITRE_MS = 42'd60000000;

    // v * 1000 as v*1024 - v*16 - v*8
    function automatic logic [PROD_W-1:0] times_1000(input logic [TOTAL_W-1:0] v);
        logic [PROD_W-1:0] w;
        w = PROD_W'(v);
        return (w << 10) - (w << 4) - (w << 3);
    endfunction

endpackage

`default_nettype wire

[rtl/fmpt_ifs.sv]
`default_nettype none

interface fmpt_in_if;
    logic                          valid;
    logic                          ready;
    logic [fmpt_pkg::OP_W-1:0]     op;
    logic [fmpt_pkg::LOAD_W-1:0]   load_value;

    modport source (output valid, op, load_value, input ready);
    modport sink   (input valid, op, load_value, output ready);
endinterface

interface fmpt_out_if;
    logic                            valid;
    logic                            ready;
    logic                            sample_done;
    logic [fmpt_pkg::WIN_W-1:0]      window_ml;
    logic [fmpt_pkg::FLOW_W-1:0]     flow_ml_per_min;
    logic [fmpt_pkg::TOTAL_W-1:0]    total_count;
    logic [fmpt_pkg::TOTAL_ML_W-1:0] total_ml;
    logic                            changed;

    modport source (output valid, sample_done, window_ml, flow_ml_per_min, total_count,
                    total_ml, changed, input ready);
    modport sink   (input valid, sample_done, window_ml, flow_ml_per_min, total_count,
                    total_ml, changed, output ready);
endinterface

interface fmpt_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fmpt_pkg::CFG_IDX_W-1:0]    index;
    logic [fmpt_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/fmpt_div.sv]
`default_nettype none

// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module fmpt_div #(
    parameter int NUM_W = fmpt_pkg::PROD_W,
    parameter int DEN_W = fmpt_pkg::PPL_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_q;     // numerator shifts out the top, quotient in the bottom

    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_rem_sh = {r_rem, r_q[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start && !o_busy) begin
            r_cnt <= CNT_W'(NUM_W);
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

[rtl/flow_meter_pulse_totalizer.sv]
`default_nettype none

// Flow meter pulse totalizer. Each transaction on i_in (pulse edge, millisecond tick,
// total load or dirty-clearing status read) yields exactly one result on o_out with the
// window volume and flow of the last closed window, the pulse total, its volume in mL
// and the dirty flag. Items are handled one at a time: an accepted item has its divider
// operands prepared in S_PREP, then waits in S_DIV for the bit-serial dividers, which
// produce one quotient bit per cycle while busy, and for a free output register; the next
// item is taken only back in S_IDLE. The result sits in an output register, so the next
// item is accepted while a result still waits. Configuration writes on i_cfg are always
// taken.
module flow_meter_pulse_totalizer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fmpt_in_if.sink     i_in,
    fmpt_out_if.source  o_out,
    fmpt_cfg_if.sink    i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV
    } t_state;

    t_state r_state;

    logic [fmpt_pkg::PPL_W-1:0]      r_ppl;
    logic [fmpt_pkg::MS_W-1:0]       r_sample_ms;
    logic [fmpt_pkg::CNT_W-1:0]      r_wc;
    logic [fmpt_pkg::MS_W-1:0]       r_el;
    logic [fmpt_pkg::TOTAL_W-1:0]    r_total;
    logic                            r_dirty;
    logic [fmpt_pkg::WIN_W-1:0]      r_last_win;
    logic [fmpt_pkg::FLOW_W-1:0]     r_last_flow;

    logic                            r_closing;
    logic                            r_changed;
    logic [fmpt_pkg::CNT_W-1:0]      r_close_n;
    logic [fmpt_pkg::MS_W-1:0]       r_close_el;

    logic                            r_out_valid;
    logic                            r_out_done;
    logic [fmpt_pkg::WIN_W-1:0]      r_out_win;
    logic [fmpt_pkg::FLOW_W-1:0]     r_out_flow;
    logic [fmpt_pkg::TOTAL_W-1:0]    r_out_total;
    logic [fmpt_pkg::TOTAL_ML_W-1:0] r_out_total_ml;
    logic                            r_out_changed;

    logic [fmpt_pkg::CNT_W-1:0]      n_wc;
    logic [fmpt_pkg::MS_W-1:0]       n_el;
    logic [fmpt_pkg::TOTAL_W-1:0]    n_total;
    logic                            n_dirty;
    logic                            n_closing;
    logic                            n_changed;
    logic [fmpt_pkg::MS_W-1:0]       w_el_inc;

    logic [fmpt_pkg::WIN_W-1:0]      n_last_win;
    logic [fmpt_pkg::FLOW_W-1:0]     n_last_flow;
    logic [fmpt_pkg::TOTAL_ML_W-1:0] n_total_ml;

    logic                            w_start;
    logic                            w_ppl_zero;
    logic [fmpt_pkg::PROD_W-1:0]     w_total_num;
    logic [fmpt_pkg::PROD_W-1:0]     w_win_prod;
    logic [fmpt_pkg::PROD_W-1:0]     w_flow_num;
    logic [fmpt_pkg::FLOW_DEN_W-1:0] w_flow_den;

    logic                            w_busy_total;
    logic                            w_busy_win;
    logic                            w_busy_flow;
    logic [fmpt_pkg::PROD_W-1:0]     w_q_total;
    logic [fmpt_pkg::WIN_W-1:0]      w_q_win;
    logic [fmpt_pkg::PROD_W-1:0]     w_q_flow;
    logic                            w_out_free;
    logic                            w_finish;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid           = r_out_valid;
    assign o_out.sample_done     = r_out_done;
    assign o_out.window_ml       = r_out_win;
    assign o_out.flow_ml_per_min = r_out_flow;
    assign o_out.total_count     = r_out_total;
    assign o_out.total_ml        = r_out_total_ml;
    assign o_out.changed         = r_out_changed;

    // Item update on acceptance
    always_comb begin
        n_wc      = r_wc;
        n_el      = r_el;
        n_total   = r_total;
        n_dirty   = r_dirty;
        n_closing = 1'b0;
        w_el_inc  = (r_el == '1) ? r_el : r_el + 1'b1;
        unique case (i_in.op)
            fmpt_pkg::OP_PULSE: begin
                if (r_wc != '1) begin
                    n_wc = r_wc + 1'b1;
                end
            end
            fmpt_pkg::OP_TICK: begin
                if (w_el_inc >= r_sample_ms) begin
                    n_closing = 1'b1;
                    n_wc      = '0;
                    n_el      = '0;
                    if (r_wc != '0) begin
                        n_total = r_total + fmpt_pkg::TOTAL_W'(r_wc);
                        n_dirty = 1'b1;
                    end
                end else begin
                    n_el = w_el_inc;
                end
            end
            fmpt_pkg::OP_LOAD: begin
                n_total = i_in.load_value;
            end
            fmpt_pkg::OP_STATUS: begin
                n_dirty = 1'b0;
            end
        endcase
        // flag as it stands before the status read clears it
        n_changed = (i_in.op == fmpt_pkg::OP_STATUS) ? r_dirty : n_dirty;
    end

    // Divider operands, taken from registers in S_PREP
    assign w_start     = (r_state == S_PREP);
    assign w_ppl_zero  = (r_ppl == '0);
    assign w_total_num = fmpt_pkg::times_1000(r_total);
    assign w_win_prod  = fmpt_pkg::times_1000(fmpt_pkg::TOTAL_W'(r_close_n));
    assign w_flow_num  = fmpt_pkg::PROD_W'(r_close_n) * fmpt_pkg::ML_MIN_PER_LITRE_MS;
    assign w_flow_den  = fmpt_pkg::FLOW_DEN_W'(r_close_el) * fmpt_pkg::FLOW_DEN_W'(r_ppl);

    fmpt_div #(
        .NUM_W (fmpt_pkg::PROD_W),
        .DEN_W (fmpt_pkg::PPL_W)
    ) u_div_total (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_total_num),
        .i_den   (r_ppl),
        .o_busy  (w_busy_total),
        .o_quot  (w_q_total)
    );

    fmpt_div #(
        .NUM_W (fmpt_pkg::WIN_W),
        .DEN_W (fmpt_pkg::PPL_W)
    ) u_div_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start & r_closing),
        .i_num   (w_win_prod[fmpt_pkg::WIN_W-1:0]),
        .i_den   (r_ppl),
        .o_busy  (w_busy_win),
        .o_quot  (w_q_win)
    );

    fmpt_div #(
        .NUM_W (fmpt_pkg::PROD_W),
        .DEN_W (fmpt_pkg::FLOW_DEN_W)
    ) u_div_flow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start & r_closing),
        .i_num   (w_flow_num),
        .i_den   (w_flow_den),
        .o_busy  (w_busy_flow),
        .o_quot  (w_q_flow)
    );

    // Result assembly once the dividers finish
    always_comb begin
        n_last_win  = r_last_win;
        n_last_flow = r_last_flow;
        if (r_closing) begin
            if (w_ppl_zero) begin
                n_last_win  = '0;
                n_last_flow = '0;
            end else begin
                n_last_win = w_q_win;
                if (w_q_flow[fmpt_pkg::PROD_W-1:fmpt_pkg::FLOW_W] != '0) begin
                    n_last_flow = '1;
                end else begin
                    n_last_flow = w_q_flow[fmpt_pkg::FLOW_W-1:0];
                end
            end
        end
        n_total_ml = w_ppl_zero ? '0 : w_q_total;
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_finish   = (r_state == S_DIV) && !w_busy_total && !w_busy_win && !w_busy_flow
                        && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ppl       <= fmpt_pkg::PPL_RESET;
            r_sample_ms <= fmpt_pkg::MS_RESET;
            r_wc        <= '0;
            r_el        <= '0;
            r_total     <= '0;
            r_dirty     <= 1'b0;
            r_last_win  <= '0;
            r_last_flow <= '0;
            r_closing   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    fmpt_pkg::CFG_PULSES_PER_LITRE: r_ppl       <= i_cfg.data;
                    fmpt_pkg::CFG_SAMPLE_MS:        r_sample_ms <= i_cfg.data;
                endcase
            end

            if (r_out_valid && o_out.ready && !w_finish) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_wc       <= n_wc;
                        r_el       <= n_el;
                        r_total    <= n_total;
                        r_dirty    <= n_dirty;
                        r_closing  <= n_closing;
                        r_changed  <= n_changed;
                        r_close_n  <= r_wc;
                        r_close_el <= w_el_inc;
                        r_state    <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_finish) begin
                        r_last_win     <= n_last_win;
                        r_last_flow    <= n_last_flow;
                        r_out_valid    <= 1'b1;
                        r_out_done     <= r_closing;
                        r_out_win      <= n_last_win;
                        r_out_flow     <= n_last_flow;
                        r_out_total    <= r_total;
                        r_out_total_ml <= n_total_ml;
                        r_out_changed  <= r_changed;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
